/* hw/rtl/sbis_pkg.sv */
// ----------------------------------------------------------------------------
// sbis_pkg
// Shared types and constants for the sparse bitmap id set.
// ----------------------------------------------------------------------------
package sbis_pkg;

    localparam int ID_W        = 64;
    localparam int WORD_BITS   = 64;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int KEY_W       = ID_W - BIT_IDX_W;
    localparam int ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_QUERY   = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    // Restart and the unused request code also report the zero code.
    typedef enum logic [3:0] {
        STS_BELOW_MIN   = 4'd0,
        STS_ABOVE_MAX   = 4'd1,
        STS_NO_ENTRY    = 4'd2,
        STS_BIT_CLEAR   = 4'd3,
        STS_FOUND       = 4'd4,
        STS_FOUND_FREED = 4'd5,
        STS_INSERTED    = 4'd6,
        STS_NOT_SORTED  = 4'd7,
        STS_TABLE_FULL  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [WORD_BITS-1:0] bits;
    } entry_t;

endpackage

/* hw/rtl/sbis_mem.sv */
// ----------------------------------------------------------------------------
// sbis_mem
// Entry table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbis_mem #(
    parameter  int ENTRIES = 64,
    localparam int IW      = $clog2(ENTRIES)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IW-1:0]    rd_addr,
    output sbis_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_addr,
    input  sbis_pkg::entry_t wr_data
);
    import sbis_pkg::*;

    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/sbis_ctrl.sv */
// ----------------------------------------------------------------------------
// sbis_ctrl
// Request sequencer: window checks, table scan, read-modify-write of the
// matching entry, entry count and the output register.
// ----------------------------------------------------------------------------
module sbis_ctrl #(
    parameter  int ENTRIES = 64,
    localparam int IW      = $clog2(ENTRIES)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [sbis_pkg::ID_W-1:0] msg_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      is_member,
    output logic [3:0]                status,
    output logic [6:0]                entries_used,
    output logic                      mem_rd_en,
    output logic [IW-1:0]             mem_rd_addr,
    input  sbis_pkg::entry_t          mem_rd_data,
    output logic                      mem_wr_en,
    output logic [IW-1:0]             mem_wr_addr,
    output sbis_pkg::entry_t          mem_wr_data
);
    import sbis_pkg::*;

    localparam int          CW   = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [ID_W-1:0]      low_reg, low_next;
    logic [ID_W-1:0]      high_reg, high_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        addr_reg, addr_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rd_vld_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_member_reg, res_member_next;
    logic                 out_valid_reg;
    logic                 out_member_reg;
    status_t              out_status_reg;
    logic [6:0]           out_used_reg;

    logic                 accept;
    logic                 issue;
    logic                 hit;
    logic                 last_beat;
    logic                 commit;
    logic                 out_load;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] bits_set;
    logic [WORD_BITS-1:0] bits_clr;
    logic                 can_alloc;
    logic [IW-1:0]        alloc_idx;

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign in_stall  = (state_reg != ST_IDLE);
    assign issue     = (state_reg == ST_SCAN) && !issue_done_reg;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    assign mem_rd_en   = issue;
    assign mem_rd_addr = addr_reg;

    assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << id_reg[BIT_IDX_W-1:0];
    assign bits_set  = mem_rd_data.bits | bit_mask;
    assign bits_clr  = mem_rd_data.bits & ~bit_mask;
    assign hit       = rd_vld_reg && mem_rd_data.valid
                       && (mem_rd_data.key == id_reg[ID_W-1:BIT_IDX_W]);
    assign last_beat = rd_vld_reg && (rd_idx_reg == LAST);
    // scan ends on the first key match or after the last entry came back
    assign commit    = (state_reg == ST_SCAN) && (hit || last_beat);
    assign can_alloc = free_found_reg || !mem_rd_data.valid;
    assign alloc_idx = free_found_reg ? free_idx_reg : rd_idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESULT;
                    if (req_t'(req_type) == REQ_INSERT && msg_id > high_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    if (req_t'(req_type) == REQ_QUERY && msg_id >= low_reg
                        && msg_id <= high_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and table access
    always_comb
    begin
        req_next        = req_reg;
        id_next         = id_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_member_next = res_member_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = addr_reg;
        mem_wr_data     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en = 1'b1;
                addr_next = addr_reg + IW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = req_t'(req_type);
                    id_next         = msg_id;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    free_found_next = 1'b0;
                    res_member_next = 1'b0;
                    res_status_next = STS_BELOW_MIN;
                    unique case (req_type)
                        REQ_INSERT:
                        begin
                            if (msg_id <= high_reg)
                            begin
                                res_status_next = STS_NOT_SORTED;
                            end
                        end
                        REQ_QUERY:
                        begin
                            if (msg_id < low_reg)
                            begin
                                res_status_next = STS_BELOW_MIN;
                            end
                            else
                            begin
                                if (msg_id == low_reg)
                                begin
                                    low_next = low_reg + ID_W'(1);
                                end
                                if (msg_id > high_reg)
                                begin
                                    res_status_next = STS_ABOVE_MAX;
                                end
                            end
                        end
                        REQ_RESTART:
                        begin
                            high_next = msg_id;
                            low_next  = msg_id + ID_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + IW'(1);
                    if (addr_reg == LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                if (rd_vld_reg && !mem_rd_data.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (commit)
                begin
                    if (req_reg == REQ_INSERT)
                    begin
                        if (hit || can_alloc)
                        begin
                            mem_wr_en        = 1'b1;
                            mem_wr_data.valid = 1'b1;
                            mem_wr_data.key  = id_reg[ID_W-1:BIT_IDX_W];
                            res_status_next  = STS_INSERTED;
                            high_next        = id_reg;
                            if (id_reg < low_reg)
                            begin
                                low_next = id_reg;
                            end
                            if (hit)
                            begin
                                mem_wr_addr      = rd_idx_reg;
                                mem_wr_data.bits = bits_set;
                            end
                            else
                            begin
                                mem_wr_addr      = alloc_idx;
                                mem_wr_data.bits = bit_mask;
                                count_next       = count_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = STS_TABLE_FULL;
                        end
                    end
                    else
                    begin
                        if (!hit)
                        begin
                            res_status_next = STS_NO_ENTRY;
                        end
                        else if ((mem_rd_data.bits & bit_mask) == '0)
                        begin
                            res_status_next = STS_BIT_CLEAR;
                        end
                        else
                        begin
                            mem_wr_en         = 1'b1;
                            mem_wr_addr       = rd_idx_reg;
                            mem_wr_data.key   = mem_rd_data.key;
                            mem_wr_data.bits  = bits_clr;
                            res_member_next   = 1'b1;
                            if (bits_clr == '0)
                            begin
                                mem_wr_data.valid = 1'b0;
                                res_status_next   = STS_FOUND_FREED;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                mem_wr_data.valid = 1'b1;
                                res_status_next   = STS_FOUND;
                            end
                        end
                    end
                end
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            low_reg        <= ID_W'(1);
            high_reg       <= '0;
            count_reg      <= '0;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            count_reg      <= count_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= issue;
            free_found_reg <= free_found_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        id_reg         <= id_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_member_reg <= res_member_next;
        if (issue)
        begin
            rd_idx_reg <= addr_reg;
        end
        if (out_load)
        begin
            out_member_reg <= res_member_reg;
            out_status_reg <= res_status_reg;
            out_used_reg   <= 7'(count_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_member    = out_member_reg;
    assign status       = out_status_reg;
    assign entries_used = out_used_reg;

endmodule

/* hw/rtl/sparse_bitmap_id_set_core.sv */
// ----------------------------------------------------------------------------
// sparse_bitmap_id_set_core
// Set of 64-bit ids held as keyed 64-bit membership words in an entry table.
//
// One request at a time. Requests that the window decides alone (out of
// order insert, query below the minimum or above the maximum, restart,
// unused code) go from accept straight to the result state and then to the
// output register. Requests that touch the table walk it one entry per cycle
// through the single read port, ending early on the first key match; a
// miss scans every entry. In both cases the next request is accepted only
// after the result has been loaded into the output register. A result
// waits in the output register while the next request is accepted; while
// that register is still full and stalled, the next result is held back
// and in_stall stays high while the stall lasts. After reset the table is
// cleared one entry per cycle, during which in_stall is high.
// ----------------------------------------------------------------------------
module sparse_bitmap_id_set_core #(
    parameter int ENTRIES = sbis_pkg::ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [sbis_pkg::ID_W-1:0] msg_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      is_member,
    output logic [3:0]                status,
    output logic [6:0]                entries_used
);
    import sbis_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;

    sbis_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .msg_id       (msg_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_member    (is_member),
        .status       (status),
        .entries_used (entries_used),
        .mem_rd_en    (rd_en),
        .mem_rd_addr  (rd_addr),
        .mem_rd_data  (rd_data),
        .mem_wr_en    (wr_en),
        .mem_wr_addr  (wr_addr),
        .mem_wr_data  (wr_data)
    );

    sbis_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // one request in flight: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a request is in flight");

    a_member_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_member |->
            (status == STS_FOUND || status == STS_FOUND_FREED))
        else $error("is_member set with a non-found status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STS_TABLE_FULL)
        else $error("status code out of range");

    // no table write while waiting for a request
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !wr_en)
        else $error("table write while idle");

endmodule
